// File: hw/rtl/kbsu_pkg.sv
package kbsu_pkg;

    localparam int MAX_LEN   = 64;
    localparam int CNT_W     = 7;
    localparam int RANK_W    = 30;
    localparam int TAB_DW    = 30;
    localparam int TAB_DEPTH = (MAX_LEN + 1) * (MAX_LEN + 1);
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    localparam logic [TAB_DW-1:0] SAT_LIMIT = TAB_DW'(1000000000);

    typedef struct packed {
        logic              en;
        logic [TAB_AW-1:0] addr;
    } tab_rd_t;

    typedef struct packed {
        logic              en;
        logic [TAB_AW-1:0] addr;
        logic [TAB_DW-1:0] data;
    } tab_wr_t;

    // row-major triangle entry (n, k)
    function automatic logic [TAB_AW-1:0] tab_addr(input logic [CNT_W-1:0] n,
                                                   input logic [CNT_W-1:0] k);
        return TAB_AW'(n) * TAB_AW'(MAX_LEN + 1) + TAB_AW'(k);
    endfunction

endpackage

// File: hw/rtl/kbsu_query_if.sv
interface kbsu_query_if import kbsu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_z;
    logic [RANK_W-1:0] rank;

    modport source (output valid, count_a, count_z, rank, input ready);
    modport sink   (input valid, count_a, count_z, rank, output ready);
endinterface

// File: hw/rtl/kbsu_result_if.sv
interface kbsu_result_if ();
    logic valid;
    logic ready;
    logic symbol;
    logic last;
    logic error;

    modport source (output valid, symbol, last, error, input ready);
    modport sink   (input valid, symbol, last, error, output ready);
endinterface

// File: hw/rtl/kbsu_table_mem.sv
module kbsu_table_mem import kbsu_pkg::*; (
    input  logic              clk,
    input  tab_wr_t           wr,
    input  tab_rd_t           rd0,
    input  tab_rd_t           rd1,
    output logic [TAB_DW-1:0] rd0_data,
    output logic [TAB_DW-1:0] rd1_data
);

    logic [TAB_DW-1:0] mem [TAB_DEPTH];
    logic [TAB_DW-1:0] rd0_data_reg;
    logic [TAB_DW-1:0] rd1_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd0.en)
        begin
            rd0_data_reg <= mem[rd0.addr];
        end
        if (rd1.en)
        begin
            rd1_data_reg <= mem[rd1.addr];
        end
    end

    assign rd0_data = rd0_data_reg;
    assign rd1_data = rd1_data_reg;

endmodule

// File: hw/rtl/kbsu_fill.sv
module kbsu_fill import kbsu_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TAB_DW-1:0] rd_data,
    output tab_rd_t           rd,
    output tab_wr_t           wr,
    output logic              done
);

    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              active_reg, active_next;
    logic              wv_reg;
    logic [CNT_W-1:0]  wn_reg;
    logic [CNT_W-1:0]  wk_reg;
    logic [TAB_DW-1:0] prev_reg;
    logic              done_reg, done_next;
    logic [TAB_DW:0]   sum;

    // issue stage: read entry (n-1, k) of the previous row
    always_comb
    begin
        rd.en   = active_reg && (k_reg < n_reg);
        rd.addr = tab_addr(n_reg - CNT_W'(1), k_reg);
        n_next      = n_reg;
        k_next      = k_reg;
        active_next = active_reg;
        if (active_reg)
        begin
            if (k_reg == n_reg)
            begin
                k_next = '0;
                if (n_reg == CNT_W'(MAX_LEN))
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    n_next = n_reg + CNT_W'(1);
                end
            end
            else
            begin
                k_next = k_reg + CNT_W'(1);
            end
        end
    end

    // write stage: C(n,k) = C(n-1,k-1) + C(n-1,k), saturated
    always_comb
    begin
        sum      = {1'b0, prev_reg} + {1'b0, rd_data};
        wr.en    = wv_reg;
        wr.addr  = tab_addr(wn_reg, wk_reg);
        if (wk_reg == '0 || wk_reg == wn_reg)
        begin
            wr.data = TAB_DW'(1);
        end
        else if (sum > {1'b0, SAT_LIMIT})
        begin
            wr.data = SAT_LIMIT;
        end
        else
        begin
            wr.data = sum[TAB_DW-1:0];
        end
        done_next = done_reg
                    || (wv_reg && wn_reg == CNT_W'(MAX_LEN) && wk_reg == CNT_W'(MAX_LEN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            k_reg      <= '0;
            active_reg <= 1'b1;
            wv_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            n_reg      <= n_next;
            k_reg      <= k_next;
            active_reg <= active_next;
            wv_reg     <= active_reg;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wn_reg <= n_reg;
        wk_reg <= k_reg;
        if (wv_reg)
        begin
            prev_reg <= rd_data;
        end
    end

    assign done = done_reg;

endmodule

// File: hw/rtl/kth_binary_string_unrank.sv
// Unranks a binary string of given composition: for count_a zeros, count_z
// ones and a one-based rank it returns the rank-th string in lexicographic
// order, one symbol per result item, with last set on the final symbol.
// A bad length (zero or above 64) or a rank above the saturated string count
// gives one item with error and last set. After reset the binomial table
// memory is built by a fill pass; no query is taken until it ends. A query
// then passes accept and a table check and gives one symbol a cycle while
// the result output is not stalled. One symbol a cycle comes from the two
// read ports of the table memory, which fetch both possible next entries
// while the current symbol is decided. A new query is taken while the final
// item still waits in the output register.
module kth_binary_string_unrank import kbsu_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    kbsu_query_if.sink   query,
    kbsu_result_if.source result
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_ERR   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [CNT_W-1:0]  z_reg, z_next;
    logic [RANK_W-1:0] skip_reg, skip_next;
    logic              sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_symbol_reg, out_symbol_next;
    logic              out_last_reg, out_last_next;
    logic              out_error_reg, out_error_next;

    tab_rd_t           fill_rd;
    tab_wr_t           fill_wr;
    logic              fill_done;
    tab_rd_t           ctrl_rd0;
    tab_rd_t           ctrl_rd1;
    tab_rd_t           mem_rd0;
    logic [TAB_DW-1:0] rd0_data;
    logic [TAB_DW-1:0] rd1_data;

    logic              accept;
    logic              out_free;
    logic              emit;
    logic [CNT_W:0]    n_in;
    logic              bad_len;
    logic [CNT_W-1:0]  ab_sum;
    logic              both;
    logic [TAB_DW-1:0] cur;
    logic              sym;

    kbsu_fill u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_data (rd0_data),
        .rd      (fill_rd),
        .wr      (fill_wr),
        .done    (fill_done)
    );

    assign mem_rd0 = fill_done ? ctrl_rd0 : fill_rd;

    kbsu_table_mem u_mem (
        .clk      (clk),
        .wr       (fill_wr),
        .rd0      (mem_rd0),
        .rd1      (ctrl_rd1),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data)
    );

    assign query.ready   = fill_done && (state_reg == ST_IDLE);
    assign accept        = query.valid && query.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign n_in          = {1'b0, query.count_a} + {1'b0, query.count_z};
    assign bad_len       = (n_in == '0) || (n_in > (CNT_W + 1)'(MAX_LEN));
    assign ab_sum        = a_reg + z_reg;
    assign both          = (a_reg != '0) && (z_reg != '0);
    assign cur           = sel_reg ? rd1_data : rd0_data;
    assign sym           = both ? !(cur > skip_reg) : (a_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        z_next          = z_reg;
        skip_next       = skip_reg;
        sel_next        = sel_reg;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        out_error_next  = out_error_reg;
        emit            = 1'b0;
        ctrl_rd0.en     = 1'b0;
        ctrl_rd0.addr   = tab_addr(ab_sum - CNT_W'(2), a_reg - CNT_W'(2));
        ctrl_rd1.en     = 1'b0;
        ctrl_rd1.addr   = tab_addr(ab_sum - CNT_W'(2), a_reg - CNT_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl_rd0.addr = tab_addr(n_in[CNT_W-1:0], query.count_a);
                ctrl_rd1.addr = tab_addr(n_in[CNT_W-1:0] - CNT_W'(1),
                                         query.count_a - CNT_W'(1));
                if (accept)
                begin
                    a_next      = query.count_a;
                    z_next      = query.count_z;
                    skip_next   = query.rank;
                    ctrl_rd0.en = !bad_len;
                    ctrl_rd1.en = !bad_len && (query.count_a != '0)
                                  && (query.count_z != '0);
                    state_next  = bad_len ? ST_ERR : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (rd0_data < skip_reg)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    skip_next  = (skip_reg == '0) ? '0 : skip_reg - RANK_W'(1);
                    sel_next   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    out_symbol_next = sym;
                    out_last_next   = (ab_sum == CNT_W'(1));
                    out_error_next  = 1'b0;
                    // fetch both candidate entries for the next symbol
                    ctrl_rd0.en     = both && (a_reg >= CNT_W'(2));
                    ctrl_rd1.en     = both;
                    sel_next        = sym;
                    if (sym)
                    begin
                        z_next = z_reg - CNT_W'(1);
                        if (both)
                        begin
                            skip_next = skip_reg - cur;
                        end
                    end
                    else
                    begin
                        a_next = a_reg - CNT_W'(1);
                    end
                    if (ab_sum == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    out_symbol_next = 1'b0;
                    out_last_next   = 1'b1;
                    out_error_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        z_reg          <= z_next;
        skip_reg       <= skip_next;
        sel_reg        <= sel_next;
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
        out_error_reg  <= out_error_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.symbol = out_symbol_reg;
    assign result.last   = out_last_reg;
    assign result.error  = out_error_reg;

    a_no_result_during_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        !fill_done |-> !result.valid
    ) else $error("result item during table fill");

    a_bad_length_to_err: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && bad_len |=> state_reg == ST_ERR
    ) else $error("bad length did not raise error");

    a_run_length_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> ({1'b0, a_reg} + {1'b0, z_reg}) <= (CNT_W + 1)'(MAX_LEN)
    ) else $error("remaining length out of range");

    a_last_ends_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        emit && out_last_next |=> state_reg == ST_IDLE && result.valid && result.last
    ) else $error("final item did not end the query");

endmodule
